// ----- src/dfw_pkg.sv -----
// ----------------------------------------------------------------------------
// dfw_pkg: shared types for the depth-first graph walk core
// Operation and status codes, and the command and status words between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dfw_pkg;

  localparam int ID_W = 4;
  localparam int CFG_W = 5;
  localparam int OP_W = 2;
  localparam int ST_W = 2;
  localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_EDGE = 2'd0,
    OP_TRAVERSE = 2'd1,
    OP_CLEAR    = 2'd2
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_VISIT = 1'b1;

  typedef struct packed {
    logic    load_item;
    logic    cnt_sel_a;
    logic    cnt_sel_b;
    logic    latch_cnt_a;
    logic    latch_cnt_b;
    logic    add_wr_a;
    logic    add_wr_b;
    logic    cnt_clear;
    logic    tr_init;
    logic    outer_start;
    logic    outer_next;
    logic    advance;
    logic    push;
    logic    pop;
    logic    pop_load;
    logic    emit_ack;
    status_e ack_status;
    logic    emit_done;
  } dfw_cmd_t;

  typedef struct packed {
    logic range_bad;
    logic list_full;
    logic outer_end;
    logic outer_seen;
    logic pos_done;
    logic last_frame;
    logic nbr_skip;
  } dfw_stat_t;

endpackage

`default_nettype wire

// ----- src/dfw_ram.sv -----
// ----------------------------------------------------------------------------
// dfw_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfw_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/dfw_ctrl.sv -----
// ----------------------------------------------------------------------------
// dfw_ctrl: sequencing state machine of the depth-first graph walk core
// Steps edge insertion, list clearing and the stack-based walk, issuing
// commands to the datapath and branching on its status flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfw_ctrl import dfw_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [OP_W-1:0] operation_i,
  input  dfw_stat_t       stat_i,
  output dfw_cmd_t        cmd_o,
  output logic            busy_o
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_ADD_RDA  = 11'b000_0000_0010,
    S_ADD_RDB  = 11'b000_0000_0100,
    S_ADD_CHK  = 11'b000_0000_1000,
    S_ADD_WRA  = 11'b000_0001_0000,
    S_ADD_WRB  = 11'b000_0010_0000,
    S_TR_OUTER = 11'b000_0100_0000,
    S_TR_READ  = 11'b000_1000_0000,
    S_TR_EVAL  = 11'b001_0000_0000,
    S_TR_POP   = 11'b010_0000_0000,
    S_TR_DONE  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o = '0;
    cmd_o.ack_status = ST_OK;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (op_e'(operation_i))
            OP_ADD_EDGE: begin
              cmd_o.load_item = 1'b1;
              state_d = S_ADD_RDA;
            end
            OP_TRAVERSE: begin
              cmd_o.tr_init = 1'b1;
              state_d = S_TR_OUTER;
            end
            OP_CLEAR: begin
              cmd_o.cnt_clear = 1'b1;
              cmd_o.emit_ack = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_ADD_RDA: begin
        cmd_o.cnt_sel_a = 1'b1;
        state_d = S_ADD_RDB;
      end
      S_ADD_RDB: begin
        cmd_o.cnt_sel_b = 1'b1;
        cmd_o.latch_cnt_a = 1'b1;
        state_d = S_ADD_CHK;
      end
      S_ADD_CHK: begin
        cmd_o.latch_cnt_b = 1'b1;
        if (stat_i.range_bad) begin
          cmd_o.emit_ack = 1'b1;
          cmd_o.ack_status = ST_RANGE;
          state_d = S_IDLE;
        end else if (stat_i.list_full) begin
          cmd_o.emit_ack = 1'b1;
          cmd_o.ack_status = ST_FULL;
          state_d = S_IDLE;
        end else begin
          state_d = S_ADD_WRA;
        end
      end
      S_ADD_WRA: begin
        cmd_o.add_wr_a = 1'b1;
        state_d = S_ADD_WRB;
      end
      S_ADD_WRB: begin
        cmd_o.add_wr_b = 1'b1;
        cmd_o.emit_ack = 1'b1;
        state_d = S_IDLE;
      end
      S_TR_OUTER: begin
        if (stat_i.outer_end) begin
          state_d = S_TR_DONE;
        end else if (stat_i.outer_seen) begin
          cmd_o.outer_next = 1'b1;
        end else begin
          cmd_o.outer_start = 1'b1;
          state_d = S_TR_READ;
        end
      end
      S_TR_READ: begin
        state_d = S_TR_EVAL;
      end
      S_TR_EVAL: begin
        if (stat_i.pos_done) begin
          cmd_o.pop = 1'b1;
          if (stat_i.last_frame) begin
            cmd_o.outer_next = 1'b1;
            state_d = S_TR_OUTER;
          end else begin
            state_d = S_TR_POP;
          end
        end else if (stat_i.nbr_skip) begin
          cmd_o.advance = 1'b1;
          state_d = S_TR_READ;
        end else begin
          cmd_o.push = 1'b1;
          state_d = S_TR_READ;
        end
      end
      S_TR_POP: begin
        cmd_o.pop_load = 1'b1;
        state_d = S_TR_READ;
      end
      S_TR_DONE: begin
        cmd_o.emit_done = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ----- src/dfw_datapath.sv -----
// ----------------------------------------------------------------------------
// dfw_datapath: storage and arithmetic of the depth-first graph walk core
// Holds the neighbor lists, list counts, discovered marks, the walk stack and
// the result register, and acts on commands from the controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfw_datapath import dfw_pkg::*; #(
  parameter int MAX_NODES = 16,
  parameter int MAX_DEGREE = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dfw_cmd_t         cmd_i,
  output dfw_stat_t        stat_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic [ID_W-1:0]  edge_source_i,
  input  logic [ID_W-1:0]  edge_target_i,
  output logic             valid_o,
  output logic             result_kind_o,
  output logic [ID_W-1:0]  visited_node_o,
  output logic             last_o,
  output logic [ST_W-1:0]  status_o
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int PW = $clog2(MAX_DEGREE + 1);
  localparam int TD = MAX_NODES * MAX_DEGREE;
  localparam int TAW = $clog2(TD);
  localparam int SW = NW + PW;

  logic [CFG_W-1:0]     node_count_q;
  logic [CW-1:0]        n_eff;
  logic [ID_W-1:0]      a_q, b_q;
  logic [NW-1:0]        a_node, b_node;
  logic [PW-1:0]        cnt_a_q, cnt_b_q, cnt_b_eff;
  logic [MAX_NODES-1:0] cnt_vld_q, mark_q;
  logic                 cnt_rd_vld_q;
  logic [NW-1:0]        cnt_raddr, cnt_waddr;
  logic [PW-1:0]        cnt_rdata, cnt_rd, cnt_wdata;
  logic                 tbl_we;
  logic [NW-1:0]        tbl_wrow, tbl_wdata, tbl_rdata;
  logic [PW-1:0]        tbl_wpos, tbl_rpos;
  logic [TAW-1:0]       tbl_waddr, tbl_raddr;
  logic [CW-1:0]        outer_q, depth_q;
  logic [NW-1:0]        cur_v_q, pend_q;
  logic [PW-1:0]        cur_pos_q;
  logic                 pend_vld_q;
  logic [SW-1:0]        stk_wdata, stk_rdata;
  logic [NW-1:0]        stk_waddr, stk_raddr;
  logic                 emit_visit, valid_d;
  logic                 valid_q, kind_q, last_q;
  logic [ID_W-1:0]      node_q;
  logic [ST_W-1:0]      status_q;

  always_comb begin
    if (node_count_q == '0) begin
      n_eff = CW'(1);
    end else if (int'(node_count_q) > MAX_NODES) begin
      n_eff = CW'(MAX_NODES);
    end else begin
      n_eff = CW'(node_count_q);
    end
  end

  assign a_node = NW'(a_q);
  assign b_node = NW'(b_q);

  // List counts: a store whose entries read as zero until written since the
  // last reset or clear.
  assign cnt_raddr = cmd_i.cnt_sel_a ? a_node : (cmd_i.cnt_sel_b ? b_node : cur_v_q);
  assign cnt_rd = cnt_rd_vld_q ? cnt_rdata : '0;
  assign cnt_b_eff = (a_q == b_q) ? PW'(cnt_a_q + 1'b1) : cnt_b_q;
  assign cnt_waddr = cmd_i.add_wr_b ? b_node : a_node;
  assign cnt_wdata = cmd_i.add_wr_b ? PW'(cnt_b_eff + 1'b1) : PW'(cnt_a_q + 1'b1);

  dfw_ram #(.WIDTH(PW), .DEPTH(MAX_NODES)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  assign tbl_we = cmd_i.add_wr_a | cmd_i.add_wr_b;
  assign tbl_wrow = cnt_waddr;
  assign tbl_wpos = cmd_i.add_wr_b ? cnt_b_eff : cnt_a_q;
  assign tbl_wdata = cmd_i.add_wr_b ? a_node : b_node;
  assign tbl_waddr = TAW'(int'(tbl_wrow) * MAX_DEGREE + int'(tbl_wpos));
  assign tbl_rpos = (int'(cur_pos_q) < MAX_DEGREE) ? cur_pos_q : '0;
  assign tbl_raddr = TAW'(int'(cur_v_q) * MAX_DEGREE + int'(tbl_rpos));

  dfw_ram #(.WIDTH(NW), .DEPTH(TD)) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // The stack holds the frames below the current one; the current frame lives
  // in cur_v_q and cur_pos_q.
  assign stk_waddr = NW'(depth_q - CW'(1));
  assign stk_raddr = NW'(depth_q - CW'(2));
  assign stk_wdata = {cur_v_q, PW'(cur_pos_q + 1'b1)};

  dfw_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  always_comb begin
    stat_o.range_bad = (int'(a_q) >= int'(n_eff)) || (int'(b_q) >= int'(n_eff));
    if (a_q == b_q) begin
      stat_o.list_full = (int'(cnt_a_q) + 2) > MAX_DEGREE;
    end else begin
      stat_o.list_full = (int'(cnt_a_q) >= MAX_DEGREE) || (int'(cnt_rd) >= MAX_DEGREE);
    end
    stat_o.outer_end = int'(outer_q) >= int'(n_eff);
    stat_o.outer_seen = mark_q[outer_q[NW-1:0]];
    stat_o.pos_done = cur_pos_q >= cnt_rd;
    stat_o.last_frame = (depth_q == CW'(1));
    stat_o.nbr_skip = (int'(tbl_rdata) >= int'(n_eff)) || mark_q[tbl_rdata] ||
                      (int'(depth_q) >= MAX_NODES);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RESET;
      cnt_vld_q <= '0;
      mark_q <= '0;
      outer_q <= '0;
      depth_q <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      if (cmd_i.cnt_clear) begin
        cnt_vld_q <= '0;
      end else if (tbl_we) begin
        cnt_vld_q[cnt_waddr] <= 1'b1;
      end
      if (cmd_i.tr_init) begin
        mark_q <= '0;
        outer_q <= '0;
        depth_q <= '0;
        pend_vld_q <= 1'b0;
      end else begin
        if (cmd_i.outer_start) begin
          mark_q[outer_q[NW-1:0]] <= 1'b1;
          depth_q <= CW'(1);
          pend_vld_q <= 1'b1;
        end
        if (cmd_i.push) begin
          mark_q[tbl_rdata] <= 1'b1;
          depth_q <= CW'(depth_q + 1'b1);
        end
        if (cmd_i.pop) begin
          depth_q <= CW'(depth_q - 1'b1);
        end
        if (cmd_i.outer_next) begin
          outer_q <= CW'(outer_q + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_rd_vld_q <= cnt_vld_q[cnt_raddr];
    if (cmd_i.load_item) begin
      a_q <= edge_source_i;
      b_q <= edge_target_i;
    end
    if (cmd_i.latch_cnt_a) begin
      cnt_a_q <= cnt_rd;
    end
    if (cmd_i.latch_cnt_b) begin
      cnt_b_q <= cnt_rd;
    end
    if (cmd_i.outer_start) begin
      cur_v_q <= outer_q[NW-1:0];
      cur_pos_q <= '0;
      pend_q <= outer_q[NW-1:0];
    end else if (cmd_i.push) begin
      cur_v_q <= tbl_rdata;
      cur_pos_q <= '0;
      pend_q <= tbl_rdata;
    end else if (cmd_i.advance) begin
      cur_pos_q <= PW'(cur_pos_q + 1'b1);
    end else if (cmd_i.pop_load) begin
      {cur_v_q, cur_pos_q} <= stk_rdata;
    end
  end

  // A visited node is held back one step so the final one can carry last.
  assign emit_visit = (cmd_i.outer_start | cmd_i.push) & pend_vld_q;
  assign valid_d = cmd_i.emit_ack | cmd_i.emit_done | emit_visit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_d) begin
      kind_q <= cmd_i.emit_ack ? KIND_ACK : KIND_VISIT;
      node_q <= cmd_i.emit_ack ? '0 : ID_W'(pend_q);
      last_q <= cmd_i.emit_ack | cmd_i.emit_done;
      status_q <= cmd_i.emit_ack ? cmd_i.ack_status : ST_OK;
    end
  end

  assign valid_o = valid_q;
  assign result_kind_o = kind_q;
  assign visited_node_o = node_q;
  assign last_o = last_q;
  assign status_o = status_q;

endmodule

`default_nettype wire

// ----- src/graph_depth_first_walk_core.sv -----
// ----------------------------------------------------------------------------
// graph_depth_first_walk_core: undirected graph store with depth-first walk
// Keeps per-node neighbor lists and walks them depth first on request.
// ----------------------------------------------------------------------------
// A command word is taken at a clock edge with start_i high and busy_o low.
// Its fields are operation_i, edge_source_i and edge_target_i. Each result
// word is shown for exactly one cycle with valid_o high; the receiver cannot
// stall, so every word must be taken when shown. last_o marks the final word
// of a command. The node count register is written through cfg_we_i and
// cfg_wdata_i; the user must do so only while the core is idle (not enforced).
// A clear answers in the cycle after it is taken. An add edge reads both list
// counts, answers if an id is out of range or a list is full, else writes both
// lists and answers; busy_o stays high until then. A traverse scans node ids,
// walks from each unvisited one through its neighbor entries, descends into
// new nodes, returns from nested frames and closes the scan. Each visited node
// is held until the next is found or the scan closes; the final word is shown
// in the first cycle with busy_o low. One command is handled at a time; the
// next one may be taken in the cycle that shows the final word of the previous
// one. Unused operation codes are dropped with no answer. Reset clears the
// neighbor lists and the walk state and sets the node count to sixteen.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module graph_depth_first_walk_core import dfw_pkg::*; #(
  parameter int MAX_NODES = 16,
  parameter int MAX_DEGREE = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [OP_W-1:0]  operation_i,
  input  logic [ID_W-1:0]  edge_source_i,
  input  logic [ID_W-1:0]  edge_target_i,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output logic             valid_o,
  output logic             result_kind_o,
  output logic [ID_W-1:0]  visited_node_o,
  output logic             last_o,
  output logic [ST_W-1:0]  status_o
);

  dfw_cmd_t  cmd;
  dfw_stat_t stat;

  dfw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy_o      (busy_o)
  );

  dfw_datapath #(
    .MAX_NODES  (MAX_NODES),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .edge_source_i  (edge_source_i),
    .edge_target_i  (edge_target_i),
    .valid_o        (valid_o),
    .result_kind_o  (result_kind_o),
    .visited_node_o (visited_node_o),
    .last_o         (last_o),
    .status_o       (status_o)
  );

endmodule

`default_nettype wire

// ----- src/dfw_checker.sv -----
// ----------------------------------------------------------------------------
// dfw_checker: port-level checks for the depth-first graph walk core
// Watches the command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfw_checker import dfw_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start_i,
  input logic            busy_o,
  input logic [OP_W-1:0] operation_i,
  input logic            valid_o,
  input logic            result_kind_o,
  input logic [ID_W-1:0] visited_node_o,
  input logic            last_o,
  input logic [ST_W-1:0] status_o
);

  a_clear_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && operation_i == OP_CLEAR |=>
      valid_o && last_o && result_kind_o == KIND_ACK && status_o == ST_OK)
    else $error("clear was not acknowledged in the next cycle");

  a_ack_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && result_kind_o == KIND_ACK |-> last_o && visited_node_o == '0)
    else $error("acknowledge word is malformed");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |-> !busy_o)
    else $error("core still busy while showing its final word");

  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> busy_o)
    else $error("core idle while more words of a command are due");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (operation_i == OP_ADD_EDGE || operation_i == OP_TRAVERSE)
      |=> busy_o)
    else $error("core did not turn busy after taking a command");

endmodule

bind graph_depth_first_walk_core dfw_checker u_dfw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .operation_i    (operation_i),
  .valid_o        (valid_o),
  .result_kind_o  (result_kind_o),
  .visited_node_o (visited_node_o),
  .last_o         (last_o),
  .status_o       (status_o)
);

`default_nettype wire

// ----- tb/graph_depth_first_walk_core_tb.sv -----
// ----------------------------------------------------------------------------
// graph_depth_first_walk_core_tb: self-checking bench for the graph walk core
// Drives add-edge, traverse, clear and unused command words under several node
// counts and sender idle patterns. A scoreboard keeps its own copy of the
// neighbor lists, predicts every result word and checks each one in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module graph_depth_first_walk_core_tb;
  import dfw_pkg::*;

  localparam int NODES = 16;
  localparam int DEGREE = 8;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEMS_PER_SETTING = 50;

  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] node;
    logic            last;
    logic [ST_W-1:0] status;
  } result_word_t;

  class dfw_scoreboard;
    int unsigned mismatches;
    logic [CFG_W-1:0] node_count;
    logic [ID_W-1:0] adj_list [NODES][DEGREE];
    int unsigned degree [NODES];
    result_word_t due_results [$];

    function new();
      mismatches = 0;
      node_count = NODE_COUNT_RESET;
      foreach (degree[i]) degree[i] = 0;
    endfunction

    function int unsigned live_nodes();
      if (node_count == 0) return 1;
      if (node_count > NODES) return NODES;
      return node_count;
    endfunction

    function void queue_word(logic kind, logic [ID_W-1:0] node, logic last,
                             status_e st);
      result_word_t w;
      w.kind = kind;
      w.node = node;
      w.last = last;
      w.status = st;
      due_results = {due_results, w};
    endfunction

    function status_e link_nodes(int unsigned a, int unsigned b);
      int unsigned n;
      n = live_nodes();
      if (a >= n || b >= n) return ST_RANGE;
      if (a == b) begin
        if (degree[a] + 2 > DEGREE) return ST_FULL;
      end else if (degree[a] >= DEGREE || degree[b] >= DEGREE) begin
        return ST_FULL;
      end
      adj_list[a][degree[a]] = ID_W'(b);
      degree[a]++;
      adj_list[b][degree[b]] = ID_W'(a);
      degree[b]++;
      return ST_OK;
    endfunction

    function void walk_graph();
      bit seen [NODES];
      int unsigned frame_node [NODES];
      int unsigned frame_pos [NODES];
      int unsigned order [$];
      int unsigned n, depth, v, w, pos;
      n = live_nodes();
      foreach (seen[i]) seen[i] = 1'b0;
      for (int unsigned s = 0; s < n; s++) begin
        if (seen[s]) continue;
        seen[s] = 1'b1;
        order = {order, s};
        frame_node[0] = s;
        frame_pos[0] = 0;
        depth = 1;
        while (depth > 0) begin
          v = frame_node[depth-1];
          pos = frame_pos[depth-1];
          if (pos >= degree[v]) begin
            depth--;
          end else begin
            w = adj_list[v][pos];
            frame_pos[depth-1] = pos + 1;
            if (w < n && !seen[w] && depth < NODES) begin
              seen[w] = 1'b1;
              order = {order, w};
              frame_node[depth] = w;
              frame_pos[depth] = 0;
              depth++;
            end
          end
        end
      end
      foreach (order[i]) begin
        queue_word(KIND_VISIT, ID_W'(order[i]), i == order.size() - 1, ST_OK);
      end
    endfunction

    function void note_word(logic [OP_W-1:0] op, logic [ID_W-1:0] a,
                            logic [ID_W-1:0] b);
      status_e st;
      case (op)
        OP_ADD_EDGE: begin
          st = link_nodes(a, b);
          queue_word(KIND_ACK, '0, 1'b1, st);
        end
        OP_TRAVERSE: walk_graph();
        OP_CLEAR: begin
          foreach (degree[i]) degree[i] = 0;
          queue_word(KIND_ACK, '0, 1'b1, ST_OK);
        end
        default: ;
      endcase
    endfunction

    task flag_mismatch(string msg);
      if (mismatches < 100) $display("%0t ns: %s", $time, msg);
      mismatches++;
    endtask

    task check_word(logic kind, logic [ID_W-1:0] node, logic last,
                    logic [ST_W-1:0] st);
      result_word_t exp;
      if (due_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result word kind %0b node %0d last %0b status %0d",
                                kind, node, last, st));
      end else begin
        exp = due_results.pop_front();
        if (kind !== exp.kind)
          flag_mismatch($sformatf("result_kind %0b, predicted %0b", kind, exp.kind));
        if (node !== exp.node)
          flag_mismatch($sformatf("visited_node %0d, predicted %0d", node, exp.node));
        if (last !== exp.last)
          flag_mismatch($sformatf("last %0b, predicted %0b", last, exp.last));
        if (st !== exp.status)
          flag_mismatch($sformatf("status %0d, predicted %0d", st, exp.status));
      end
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  logic [OP_W-1:0]  operation_i;
  logic [ID_W-1:0]  edge_source_i;
  logic [ID_W-1:0]  edge_target_i;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic             valid_o;
  logic             result_kind_o;
  logic [ID_W-1:0]  visited_node_o;
  logic             last_o;
  logic [ST_W-1:0]  status_o;

  dfw_scoreboard graph_sb = new();
  int unsigned quiet_cycles = 0;

  graph_depth_first_walk_core #(
    .MAX_NODES(NODES),
    .MAX_DEGREE(DEGREE)
  ) i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .busy_o(busy_o),
    .operation_i(operation_i),
    .edge_source_i(edge_source_i),
    .edge_target_i(edge_target_i),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .valid_o(valid_o),
    .result_kind_o(result_kind_o),
    .visited_node_o(visited_node_o),
    .last_o(last_o),
    .status_o(status_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) begin
        graph_sb.check_word(result_kind_o, visited_node_o, last_o, status_o);
      end
      if (start_i && !busy_o) begin
        graph_sb.note_word(operation_i, edge_source_i, edge_target_i);
      end
      if (valid_o || (start_i && !busy_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic issue_command(input logic [OP_W-1:0] op, input logic [ID_W-1:0] a,
                               input logic [ID_W-1:0] b);
    @(negedge clk_i);
    start_i = 1'b1;
    operation_i = op;
    edge_source_i = a;
    edge_target_i = b;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic maybe_pause(input int unsigned idle_pct);
    int unsigned gap;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      @(negedge clk_i);
      start_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start_i = 1'b0;
    while (graph_sb.due_results.size() != 0 || busy_o) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_node_count(input logic [CFG_W-1:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    graph_sb.node_count = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic random_item();
    int unsigned n, pick, hi, a, b;
    n = graph_sb.live_nodes();
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      hi = (n > 4 && $urandom_range(0, 1) == 1) ? 3 : n - 1;
      a = $urandom_range(0, hi);
      b = $urandom_range(0, n - 1);
      if ($urandom_range(0, 1) == 1) issue_command(OP_ADD_EDGE, ID_W'(a), ID_W'(b));
      else issue_command(OP_ADD_EDGE, ID_W'(b), ID_W'(a));
    end else if (pick < 80) begin
      a = $urandom_range(0, 15);
      b = (n < NODES) ? $urandom_range(n, 15) : $urandom_range(0, 15);
      if ($urandom_range(0, 1) == 1) issue_command(OP_ADD_EDGE, ID_W'(a), ID_W'(b));
      else issue_command(OP_ADD_EDGE, ID_W'(b), ID_W'(a));
    end else if (pick < 92) begin
      issue_command(OP_TRAVERSE, ID_W'($urandom_range(0, 15)), ID_W'($urandom_range(0, 15)));
    end else if (pick < 96) begin
      issue_command(OP_CLEAR, ID_W'($urandom_range(0, 15)), ID_W'($urandom_range(0, 15)));
    end else begin
      issue_command(OP_UNUSED, ID_W'($urandom_range(0, 15)), ID_W'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    int unsigned idle_plan [3];
    logic [CFG_W-1:0] count_plan [9];
    logic [CFG_W-1:0] setting;
    idle_plan = '{14, 64, 0};
    count_plan = '{5'd31, 5'd5, 5'd1, 5'd0, 5'd16, 5'd3, 5'd17, 5'd11, 5'd8};
    rst_ni = 1'b0;
    start_i = 1'b0;
    operation_i = OP_ADD_EDGE;
    edge_source_i = '0;
    edge_target_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty graph, self-loop, duplicate edge, then fill node 5 until both
    // sides and a self-loop are refused as full.
    issue_command(OP_TRAVERSE, 4'd15, 4'd15);
    issue_command(OP_ADD_EDGE, 4'd0, 4'd15);
    issue_command(OP_ADD_EDGE, 4'd3, 4'd3);
    issue_command(OP_ADD_EDGE, 4'd15, 4'd0);
    issue_command(OP_ADD_EDGE, 4'd5, 4'd1);
    issue_command(OP_ADD_EDGE, 4'd5, 4'd2);
    issue_command(OP_ADD_EDGE, 4'd5, 4'd3);
    issue_command(OP_ADD_EDGE, 4'd5, 4'd4);
    issue_command(OP_ADD_EDGE, 4'd5, 4'd6);
    issue_command(OP_ADD_EDGE, 4'd5, 4'd7);
    issue_command(OP_ADD_EDGE, 4'd5, 4'd8);
    issue_command(OP_ADD_EDGE, 4'd5, 4'd9);
    issue_command(OP_ADD_EDGE, 4'd5, 4'd10);
    issue_command(OP_ADD_EDGE, 4'd10, 4'd5);
    issue_command(OP_ADD_EDGE, 4'd5, 4'd5);
    issue_command(OP_TRAVERSE, 4'd0, 4'd0);

    // Shrinking the node count leaves stale neighbors and puts ids in range
    // of rejection.
    write_node_count(5'd7);
    issue_command(OP_TRAVERSE, 4'd3, 4'd12);
    issue_command(OP_ADD_EDGE, 4'd2, 4'd7);
    issue_command(OP_ADD_EDGE, 4'd9, 4'd1);
    issue_command(OP_ADD_EDGE, 4'd15, 4'd15);
    issue_command(OP_UNUSED, 4'd15, 4'd15);
    issue_command(OP_CLEAR, 4'd0, 4'd0);
    issue_command(OP_TRAVERSE, 4'd0, 4'd0);

    for (int ph = 0; ph < 3; ph++) begin
      for (int s = 0; s < 3; s++) begin
        setting = count_plan[ph*3 + s];
        if (ph == 2 && s == 1) setting = CFG_W'($urandom_range(2, 15));
        write_node_count(setting);
        for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
          maybe_pause(idle_plan[ph]);
          if ($urandom_range(0, 59) == 0) wait_idle();
          random_item();
        end
      end
    end

    wait_idle();
    if (graph_sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
